/* sv/sdcr_pkg.sv */
// Package for the SATA device command responder.
// Holds shared constants, command and function codes and the result entry type.
// No dependencies.
package sdcr_pkg;

    localparam int SLOTS_DEFAULT = 33;
    localparam int MAX_RESULTS   = 10;

    localparam logic [1:0] FUNC_REG_FIS   = 2'd0;
    localparam logic [1:0] FUNC_DMA_SETUP = 2'd1;
    localparam logic [1:0] FUNC_DISK_DONE = 2'd2;

    localparam logic [1:0] OUTCOME_OK      = 2'd0;
    localparam logic [1:0] OUTCOME_UNSUP   = 2'd1;
    localparam logic [1:0] OUTCOME_REFUSED = 2'd2;

    localparam logic [7:0] FIS_TYPE_D2H       = 8'h34;
    localparam logic [7:0] FIS_TYPE_PIO_SETUP = 8'h5f;
    localparam logic [7:0] DMA_SETUP_FIS_TYPE = 8'h41;

    localparam logic [7:0] CMD_READ_PIO       = 8'h20;
    localparam logic [7:0] CMD_READ_PIO_EXT   = 8'h24;
    localparam logic [7:0] CMD_READ_DMA_EXT   = 8'h25;
    localparam logic [7:0] CMD_READ_MULT_EXT  = 8'h29;
    localparam logic [7:0] CMD_READ_MULT      = 8'hc4;
    localparam logic [7:0] CMD_READ_DMA       = 8'hc8;
    localparam logic [7:0] CMD_WRITE_PIO      = 8'h30;
    localparam logic [7:0] CMD_WRITE_PIO_EXT  = 8'h34;
    localparam logic [7:0] CMD_WRITE_DMA_EXT  = 8'h35;
    localparam logic [7:0] CMD_WRITE_MULT_EXT = 8'h39;
    localparam logic [7:0] CMD_WRITE_MULT     = 8'hc5;
    localparam logic [7:0] CMD_WRITE_DMA      = 8'hca;
    localparam logic [7:0] CMD_READ_FPDMA     = 8'h60;
    localparam logic [7:0] CMD_WRITE_FPDMA    = 8'h61;
    localparam logic [7:0] CMD_VERIFY         = 8'h40;
    localparam logic [7:0] CMD_VERIFY_NR      = 8'h41;
    localparam logic [7:0] CMD_VERIFY_EXT     = 8'h42;
    localparam logic [7:0] CMD_SET_FEATURES   = 8'hef;
    localparam logic [7:0] CMD_FREEZE_LOCK    = 8'hf5;
    localparam logic [7:0] CMD_SET_MULTIPLE   = 8'hc6;
    localparam logic [7:0] CMD_STANDBY        = 8'he0;
    localparam logic [7:0] CMD_IDENTIFY       = 8'hec;

    localparam logic [31:0] ATAPI_SIG_LBA = 32'h00eb1401;
    localparam logic [31:0] ATA_SIG_LBA   = 32'h00000001;
    localparam logic [31:0] LBA28_MASK    = 32'h0fffffff;
    localparam logic [31:0] PIO_XFER_LEN  = 32'd512;

    typedef struct packed {
        logic        kind;
        logic [31:0] word;
    } res_entry_t;

endpackage

/* sv/sdcr_req_if.sv */
// Request channel interface of the SATA device command responder.
// Depends on nothing.
interface sdcr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [5:0]  tag;

    modport source (output valid, func, word0, word1, word2, word3, tag, input ready);
    modport sink (input valid, func, word0, word1, word2, word3, tag, output ready);
endinterface

/* sv/sdcr_rsp_if.sv */
// Result channel interface of the SATA device command responder.
// Depends on nothing.
interface sdcr_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] fis_word;
    logic [47:0] disk_sector;
    logic [16:0] disk_sectors;
    logic        disk_is_read;
    logic [5:0]  disk_slot;
    logic [1:0]  outcome;
    logic        last;

    modport source (output valid, kind, fis_word, disk_sector, disk_sectors, disk_is_read,
                    disk_slot, outcome, last, input ready);
    modport sink (input valid, kind, fis_word, disk_sector, disk_sectors, disk_is_read,
                  disk_slot, outcome, last, output ready);
endinterface

/* sv/sata_device_command_responder.sv */
// SATA device command responder: top level with decode, state and result sequencer.
// Depends on sdcr_pkg, sdcr_req_if, sdcr_rsp_if and sdcr_slot_mem.
//
// This block answers host requests as the device end of a SATA link. When a request
// is taken, in the next cycle the outstanding count of its slot comes back from the
// slot memory, the command is decoded, all state is updated and the result dwords
// are loaded into a ten-entry result buffer. Results then leave at one per cycle
// while the result channel is ready. The next request is taken in the cycle in which
// the last result is taken; none is taken while a request is being decoded, because
// the slot memory read must see the count written by the previous request. The
// outstanding counts live in a memory with a valid bit per slot, so reset and the
// soft reset signature clear them at once with no clearing pass.
module sata_device_command_responder #(
    parameter int SLOTS = sdcr_pkg::SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    sdcr_req_if.sink   req,
    sdcr_rsp_if.source rsp
);
    import sdcr_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Architectural state.
    logic [31:0] s0_reg, s1_reg, s2_reg, s3_reg;
    logic [7:0]  ctrl_reg, st_reg, er_reg, mc_reg;
    logic [5:0]  cs_reg;
    logic [31:0] rc_reg;
    logic        atapi_reg;
    logic [SLOTS-1:0] ovalid_reg;

    // Decode stage: the request waiting for its slot memory read.
    logic        dec_valid_reg;
    logic [1:0]  func_reg;
    logic [31:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic [5:0]  slot_reg;

    // Result buffer and sequencer.
    res_entry_t  buf_reg [MAX_RESULTS];
    logic [3:0]  n_reg, idx_reg;
    logic        busy_reg;
    logic [1:0]  outcome_reg;
    logic [47:0] sector_reg;
    logic [16:0] sectors_reg;
    logic        rd_reg;
    logic [5:0]  dslot_reg;

    logic [7:0] mem_rdata;
    logic       accept, out_fire, out_last;
    logic [5:0] rd_slot;

    // Decode results.
    logic [31:0] s0_next, s1_next, s2_next, s3_next, rc_next;
    logic [7:0]  ctrl_next, st_next, er_next, mc_next;
    logic [5:0]  cs_next;
    res_entry_t  buf_next [MAX_RESULTS];
    logic [3:0]  n_next;
    logic [1:0]  outcome_next;
    logic [47:0] sector_next;
    logic [16:0] sectors_next;
    logic        rd_next;
    logic        wr_en;
    logic [7:0]  wr_data;
    logic        clr_valid;

    assign out_last = (idx_reg == n_reg - 4'd1);
    assign out_fire = busy_reg && rsp.ready;
    assign req.ready = !dec_valid_reg && (!busy_reg || (rsp.ready && out_last));
    assign accept   = req.valid && req.ready;
    // Register FISes work on the current slot; DMA setups and completions carry
    // their own tag.
    assign rd_slot  = (req.func == FUNC_REG_FIS) ? cs_reg : req.tag;

    sdcr_slot_mem #(.SLOTS(SLOTS), .AW(AW)) u_slot_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_slot[AW-1:0]),
        .rd_data (mem_rdata),
        .wr_en   (wr_en && dec_valid_reg),
        .wr_addr (slot_reg[AW-1:0]),
        .wr_data (wr_data)
    );

    always_comb
    begin
        logic [7:0]  o;
        logic        in_range;
        logic        do_pio, do_dma, dma_rd, do_xfer, xfer_rd, xfer_ext, do_d2h, unsup;
        logic        refused;
        logic [7:0]  cmd;
        logic [15:0] feat, cnt;
        logic [3:0]  n;
        logic [47:0] sec;
        logic [16:0] secs;

        s0_next = s0_reg; s1_next = s1_reg; s2_next = s2_reg; s3_next = s3_reg;
        ctrl_next = ctrl_reg; st_next = st_reg; er_next = er_reg; mc_next = mc_reg;
        cs_next = cs_reg; rc_next = rc_reg;
        wr_en = 1'b0; wr_data = 8'd0; clr_valid = 1'b0;
        do_pio = 1'b0; do_dma = 1'b0; dma_rd = 1'b0; do_xfer = 1'b0; xfer_rd = 1'b0;
        xfer_ext = 1'b0; do_d2h = 1'b0; unsup = 1'b0; refused = 1'b0;
        outcome_next = OUTCOME_OK;
        cmd = 8'd0; feat = 16'd0; cnt = 16'd0;
        sec = 48'd0; secs = 17'd0;

        in_range = ({1'b0, slot_reg} < 7'(SLOTS));
        o = (in_range && ovalid_reg[slot_reg[AW-1:0]]) ? mem_rdata : 8'd0;

        unique case (func_reg)
            FUNC_REG_FIS:
            begin
                if (ctrl_reg[2] && w0_reg[15])
                begin
                    // Reset is being held: answer with status only.
                    do_d2h = 1'b1;
                end
                else
                begin
                    s0_next = w0_reg; s1_next = w1_reg; s2_next = w2_reg; s3_next = w3_reg;
                    if (w0_reg[15])
                    begin
                        cmd = w0_reg[23:16];
                        unique case (cmd)
                            CMD_READ_PIO_EXT, CMD_READ_DMA_EXT, CMD_READ_MULT_EXT,
                            CMD_READ_PIO, CMD_READ_MULT, CMD_READ_DMA:
                            begin
                                xfer_ext = (cmd == CMD_READ_PIO_EXT) ||
                                           (cmd == CMD_READ_DMA_EXT) ||
                                           (cmd == CMD_READ_MULT_EXT);
                                do_dma = (cmd == CMD_READ_DMA_EXT) || (cmd == CMD_READ_DMA);
                                do_pio = !do_dma;
                                dma_rd = 1'b1;
                                do_xfer = 1'b1; xfer_rd = 1'b1;
                            end
                            CMD_WRITE_PIO_EXT, CMD_WRITE_DMA_EXT, CMD_WRITE_MULT_EXT,
                            CMD_WRITE_PIO, CMD_WRITE_MULT, CMD_WRITE_DMA:
                            begin
                                xfer_ext = (cmd == CMD_WRITE_PIO_EXT) ||
                                           (cmd == CMD_WRITE_DMA_EXT) ||
                                           (cmd == CMD_WRITE_MULT_EXT);
                                do_dma = (cmd == CMD_WRITE_DMA_EXT) || (cmd == CMD_WRITE_DMA);
                                do_pio = !do_dma;
                                do_xfer = 1'b1;
                            end
                            CMD_READ_FPDMA, CMD_WRITE_FPDMA:
                            begin
                                // Queued commands carry the count in the feature fields.
                                feat = w3_reg[15:0];
                                cnt = {w2_reg[31:24], w0_reg[31:24]};
                                s3_next = {w3_reg[31:16], cnt};
                                s0_next = {feat[7:0], w0_reg[23:0]};
                                s2_next = {feat[15:8], w2_reg[23:0]};
                                do_dma = 1'b1; dma_rd = (cmd == CMD_READ_FPDMA);
                                do_xfer = 1'b1; xfer_rd = dma_rd; xfer_ext = 1'b1;
                            end
                            CMD_VERIFY, CMD_VERIFY_NR, CMD_VERIFY_EXT, CMD_SET_FEATURES,
                            CMD_FREEZE_LOCK:
                            begin
                                do_d2h = 1'b1;
                            end
                            CMD_SET_MULTIPLE:
                            begin
                                mc_next = w3_reg[7:0];
                                do_d2h = 1'b1;
                            end
                            CMD_STANDBY:
                            begin
                                er_next = er_reg | 8'h04;
                                st_next = st_reg | 8'h01;
                                do_d2h = 1'b1;
                            end
                            CMD_IDENTIFY:
                            begin
                                do_pio = 1'b1;
                                do_d2h = 1'b1;
                            end
                            default:
                            begin
                                unsup = 1'b1;
                                outcome_next = OUTCOME_UNSUP;
                            end
                        endcase
                    end
                    else
                    begin
                        ctrl_next = w3_reg[31:24];
                        if (w3_reg[26])
                        begin
                            // Soft reset: load the device signature.
                            s3_next = 32'd1;
                            s2_next = 32'd0;
                            s1_next = atapi_reg ? ATAPI_SIG_LBA : ATA_SIG_LBA;
                            st_next = 8'h40;
                            er_next = 8'h01;
                            ctrl_next = 8'h00;
                            clr_valid = 1'b1;
                        end
                        do_d2h = 1'b1;
                    end
                end
            end
            FUNC_DMA_SETUP:
            begin
                rc_next = w3_reg;
                cs_next = slot_reg;
            end
            FUNC_DISK_DONE:
            begin
                if (in_range && (o != 8'd0))
                begin
                    wr_en = 1'b1;
                    wr_data = o - 8'd1;
                    if (o == 8'd1)
                    begin
                        cs_next = slot_reg;
                        do_d2h = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (do_xfer)
        begin
            if (xfer_ext)
            begin
                secs = (s3_next[15:0] == 16'd0) ? 17'h10000 : {1'b0, s3_next[15:0]};
                sec = {s2_next[23:0], s1_next[23:0]};
            end
            else
            begin
                secs = (s3_next[7:0] == 8'd0) ? 17'h100 : {9'd0, s3_next[7:0]};
                sec = {16'd0, s1_next & LBA28_MASK};
            end
            refused = (rc_reg == 32'd0) || !in_range || (o != 8'd0);
            if (refused)
            begin
                outcome_next = OUTCOME_REFUSED;
            end
            else
            begin
                wr_en = 1'b1;
                wr_data = o + 8'd1;
            end
        end
        sector_next = sec;
        sectors_next = secs;
        rd_next = xfer_rd;

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            buf_next[i] = '0;
        end
        n = 4'd0;
        if (do_pio)
        begin
            st_next = (st_next & 8'h7f) | 8'h08;
            buf_next[n] = '{1'b0, {er_next, st_next, 2'b00, 1'b1, 1'b0, s0_next[11:8],
                                   FIS_TYPE_PIO_SETUP}};
            buf_next[n + 4'd1] = '{1'b0, s1_next};
            buf_next[n + 4'd2] = '{1'b0, s2_next};
            buf_next[n + 4'd3] = '{1'b0, {st_next, 8'd0, s3_next[15:0]}};
            buf_next[n + 4'd4] = '{1'b0, PIO_XFER_LEN};
            n = n + 4'd5;
        end
        if (do_dma)
        begin
            buf_next[n] = '{1'b0, {20'h00000, 1'b1, 1'b0, dma_rd, 1'b0, DMA_SETUP_FIS_TYPE}};
            n = n + 4'd7;
        end
        if (do_xfer && !refused)
        begin
            buf_next[n] = '{1'b1, 32'd0};
            n = n + 4'd1;
        end
        if (do_d2h)
        begin
            st_next = st_next & 8'hf7;
            buf_next[n] = '{1'b0, {er_next, st_next, 1'b0, 1'b1, 2'b00, s0_next[11:8],
                                   FIS_TYPE_D2H}};
            buf_next[n + 4'd1] = '{1'b0, s1_next};
            buf_next[n + 4'd2] = '{1'b0, s2_next};
            buf_next[n + 4'd3] = '{1'b0, {16'd0, s3_next[15:0]}};
            buf_next[n + 4'd4] = '{1'b0, {26'd0, cs_next}};
            cs_next = 6'd0;
            n = n + 4'd5;
        end
        if (unsup)
        begin
            buf_next[n] = '{1'b0, 32'd0};
            n = n + 4'd1;
        end
        n_next = n;
    end

    // State and the decode stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0; s1_reg <= '0; s2_reg <= '0; s3_reg <= '0;
            ctrl_reg <= '0; st_reg <= '0; er_reg <= '0; mc_reg <= '0;
            cs_reg <= '0; rc_reg <= '0;
            atapi_reg <= 1'b0;
            ovalid_reg <= '0;
            dec_valid_reg <= 1'b0;
            busy_reg <= 1'b0;
            n_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                atapi_reg <= cfg_wdata;
            end
            dec_valid_reg <= accept;
            if (dec_valid_reg)
            begin
                s0_reg <= s0_next; s1_reg <= s1_next; s2_reg <= s2_next; s3_reg <= s3_next;
                ctrl_reg <= ctrl_next; st_reg <= st_next; er_reg <= er_next;
                mc_reg <= mc_next; cs_reg <= cs_next; rc_reg <= rc_next;
                if (clr_valid)
                begin
                    ovalid_reg <= '0;
                end
                else if (wr_en)
                begin
                    ovalid_reg[slot_reg[AW-1:0]] <= 1'b1;
                end
                n_reg <= n_next;
                idx_reg <= '0;
                busy_reg <= (n_next != 4'd0);
            end
            else if (out_fire)
            begin
                if (out_last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 4'd1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            w0_reg <= req.word0; w1_reg <= req.word1;
            w2_reg <= req.word2; w3_reg <= req.word3;
            slot_reg <= rd_slot;
        end
        if (dec_valid_reg)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_reg[i] <= buf_next[i];
            end
            outcome_reg <= outcome_next;
            sector_reg <= sector_next;
            sectors_reg <= sectors_next;
            rd_reg <= rd_next;
            dslot_reg <= slot_reg;
        end
    end

    always_comb
    begin
        res_entry_t e;
        e = buf_reg[idx_reg];
        rsp.valid = busy_reg;
        rsp.kind = e.kind;
        rsp.fis_word = e.word;
        rsp.disk_sector = e.kind ? sector_reg : 48'd0;
        rsp.disk_sectors = e.kind ? sectors_reg : 17'd0;
        rsp.disk_is_read = e.kind ? rd_reg : 1'b0;
        rsp.disk_slot = e.kind ? dslot_reg : 6'd0;
        rsp.outcome = outcome_reg;
        rsp.last = out_last;
    end
endmodule

/* sv/sdcr_slot_mem.sv */
// Per-slot outstanding counter memory, one read and one write port.
// Read data is registered; depends on nothing.
module sdcr_slot_mem #(
    parameter int SLOTS = 33,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);
    logic [7:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* test/tb_sata_device_command_responder.sv */
// Testbench for the SATA device command responder: directed request table, then random
// command sequences, every result checked against a predictor of the drive behavior.
// Depends on sdcr_pkg, sdcr_req_if, sdcr_rsp_if and the block under test.
`timescale 1ns / 100ps

module tb_sata_device_command_responder;
    import sdcr_pkg::*;

    localparam int NSLOT = SLOTS_DEFAULT;
    localparam int QUIET_LIMIT = 20000;

    // One expected result, laid out as the result channel carries it.
    typedef struct {
        logic        kind;
        logic [31:0] fis_word;
        logic [47:0] sector;
        logic [16:0] sectors;
        logic        is_read;
        logic [5:0]  slot;
        logic [1:0]  outcome;
        logic        last;
    } drive_result_t;

    // One row of the directed table. When has_first is set, the first result
    // word is typed in and compared with what the predictor gives.
    typedef struct {
        logic [1:0]  func;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [5:0]  tag;
        logic        has_first;
        logic [31:0] first_word;
        logic [1:0]  first_outcome;
    } request_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    sdcr_req_if req_ch ();
    sdcr_rsp_if rsp_ch ();

    sata_device_command_responder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req_ch.sink),
        .rsp      (rsp_ch.source)
    );

    // Mirror of the drive state that the predictor updates.
    logic [31:0] task_file [4];
    logic [7:0]  ctrl_reg;
    logic [7:0]  stat_reg;
    logic [7:0]  err_reg;
    logic [7:0]  mult_count;
    logic [5:0]  xfer_slot;
    logic [31:0] region_cnt;
    logic [7:0]  busy_count [NSLOT];
    logic        atapi_mode;

    drive_result_t pending_results[$];
    drive_result_t step_results[$];
    int error_count;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void push_word(input logic [31:0] w);
        drive_result_t r;
        r = '{kind: 1'b0, fis_word: w, sector: '0, sectors: '0, is_read: 1'b0, slot: '0,
              outcome: '0, last: 1'b0};
        step_results.push_back(r);
    endfunction

    function automatic void emit_d2h();
        stat_reg = stat_reg & ~8'h08;
        push_word({err_reg, stat_reg, 16'h4000} | (task_file[0] & 32'h0f00)
                  | 32'(FIS_TYPE_D2H));
        push_word(task_file[1]);
        push_word(task_file[2]);
        push_word(task_file[3] & 32'hffff);
        push_word(32'(xfer_slot));
        xfer_slot = '0;
    endfunction

    function automatic void emit_pio_setup();
        stat_reg = (stat_reg & ~8'h80) | 8'h08;
        push_word({err_reg, stat_reg, 16'h2000} | (task_file[0] & 32'h0f00)
                  | 32'(FIS_TYPE_PIO_SETUP));
        push_word(task_file[1]);
        push_word(task_file[2]);
        push_word({stat_reg, 8'h00, task_file[3][15:0]});
        push_word(PIO_XFER_LEN);
    endfunction

    function automatic void emit_dma_setup(input logic rd);
        push_word(32'h800 | (rd ? 32'h200 : 32'h0) | 32'(DMA_SETUP_FIS_TYPE));
        for (int i = 1; i < 7; i++)
            push_word('0);
    endfunction

    // Queues the disk request; a nonzero return means the transfer was refused.
    function automatic logic begin_transfer(input logic rd, input logic ext);
        logic [47:0] lba;
        logic [16:0] cnt;
        drive_result_t r;
        if (ext)
        begin
            cnt = task_file[3][15:0] == 0 ? 17'h10000 : 17'(task_file[3][15:0]);
            lba = {task_file[2][23:0], task_file[1][23:0]};
        end
        else
        begin
            cnt = task_file[3][7:0] == 0 ? 17'h100 : 17'(task_file[3][7:0]);
            lba = 48'(task_file[1] & LBA28_MASK);
        end
        if (region_cnt == 0 || xfer_slot >= NSLOT || busy_count[xfer_slot] != 0)
            return 1'b1;
        busy_count[xfer_slot]++;
        r = '{kind: 1'b1, fis_word: '0, sector: lba, sectors: cnt, is_read: rd,
              slot: xfer_slot, outcome: '0, last: 1'b0};
        step_results.push_back(r);
        return 1'b0;
    endfunction

    function automatic logic [1:0] run_command();
        logic [7:0] opcode;
        logic [15:0] feat;
        logic [15:0] cnt;
        logic rd;
        opcode = task_file[0][23:16];
        case (opcode)
            CMD_READ_PIO, CMD_READ_MULT, CMD_READ_PIO_EXT, CMD_READ_MULT_EXT,
            CMD_READ_DMA, CMD_READ_DMA_EXT,
            CMD_WRITE_PIO, CMD_WRITE_MULT, CMD_WRITE_PIO_EXT, CMD_WRITE_MULT_EXT,
            CMD_WRITE_DMA, CMD_WRITE_DMA_EXT:
            begin
                rd = opcode inside {CMD_READ_PIO, CMD_READ_MULT, CMD_READ_PIO_EXT,
                                    CMD_READ_MULT_EXT, CMD_READ_DMA, CMD_READ_DMA_EXT};
                if (opcode inside {CMD_READ_DMA, CMD_READ_DMA_EXT, CMD_WRITE_DMA,
                                   CMD_WRITE_DMA_EXT})
                    emit_dma_setup(rd);
                else
                    emit_pio_setup();
                return begin_transfer(rd, opcode inside {CMD_READ_PIO_EXT,
                    CMD_READ_DMA_EXT, CMD_READ_MULT_EXT, CMD_WRITE_PIO_EXT,
                    CMD_WRITE_DMA_EXT, CMD_WRITE_MULT_EXT}) ? OUTCOME_REFUSED : OUTCOME_OK;
            end
            CMD_READ_FPDMA, CMD_WRITE_FPDMA:
            begin
                // Queued commands carry the count in the feature fields and the
                // feature in the count field; swap them in the task file.
                feat = task_file[3][15:0];
                cnt = {task_file[2][31:24], task_file[0][31:24]};
                task_file[3] = {task_file[3][31:16], cnt};
                task_file[0] = {feat[7:0], task_file[0][23:0]};
                task_file[2] = {feat[15:8], task_file[2][23:0]};
                emit_dma_setup(opcode == CMD_READ_FPDMA);
                return begin_transfer(opcode == CMD_READ_FPDMA, 1'b1)
                       ? OUTCOME_REFUSED : OUTCOME_OK;
            end
            CMD_VERIFY, CMD_VERIFY_NR, CMD_VERIFY_EXT, CMD_SET_FEATURES, CMD_FREEZE_LOCK:
            begin
                emit_d2h();
                return OUTCOME_OK;
            end
            CMD_SET_MULTIPLE:
            begin
                mult_count = task_file[3][7:0];
                emit_d2h();
                return OUTCOME_OK;
            end
            CMD_STANDBY:
            begin
                err_reg |= 8'h04;
                stat_reg |= 8'h01;
                emit_d2h();
                return OUTCOME_OK;
            end
            CMD_IDENTIFY:
            begin
                emit_pio_setup();
                emit_d2h();
                return OUTCOME_OK;
            end
            default:
            begin
                push_word('0);
                return OUTCOME_UNSUP;
            end
        endcase
    endfunction

    function automatic void clear_drive_state();
        foreach (task_file[i])
            task_file[i] = '0;
        ctrl_reg = '0;
        stat_reg = '0;
        err_reg = '0;
        mult_count = '0;
        xfer_slot = '0;
        region_cnt = '0;
        foreach (busy_count[i])
            busy_count[i] = '0;
        atapi_mode = 1'b0;
    endfunction

    // Predicts the results of one request and leaves them in step_results.
    function automatic void predict_drive(input request_row_t rq);
        logic [1:0] oc;
        oc = OUTCOME_OK;
        step_results.delete();
        if (rq.func == FUNC_REG_FIS)
        begin
            if (ctrl_reg[2] && rq.w0[15])
                emit_d2h();
            else
            begin
                task_file[0] = rq.w0;
                task_file[1] = rq.w1;
                task_file[2] = rq.w2;
                task_file[3] = rq.w3;
                if (task_file[0][15])
                    oc = run_command();
                else
                begin
                    ctrl_reg = task_file[3][31:24];
                    if (ctrl_reg[2])
                    begin
                        // Soft reset: load the signature and drop all outstanding slots.
                        task_file[3] = 32'd1;
                        task_file[2] = '0;
                        task_file[1] = atapi_mode ? ATAPI_SIG_LBA : ATA_SIG_LBA;
                        stat_reg = 8'h40;
                        err_reg = 8'h01;
                        ctrl_reg = '0;
                        foreach (busy_count[i])
                            busy_count[i] = '0;
                    end
                    emit_d2h();
                end
            end
        end
        else if (rq.func == FUNC_DMA_SETUP)
        begin
            region_cnt = rq.w3;
            xfer_slot = rq.tag;
        end
        else if (rq.func == FUNC_DISK_DONE)
        begin
            if (rq.tag < NSLOT && busy_count[rq.tag] != 0)
            begin
                busy_count[rq.tag]--;
                if (busy_count[rq.tag] == 0)
                begin
                    xfer_slot = rq.tag;
                    emit_d2h();
                end
            end
        end
        foreach (step_results[i])
        begin
            step_results[i].outcome = oc;
            step_results[i].last = (i == step_results.size() - 1);
        end
    endfunction

    // Sends one request, waits for it to be taken, and queues its predicted results.
    // Valid stays up after the request is taken until the next request replaces it,
    // an idle gap drops it, or the results are drained.
    task automatic send_request(input request_row_t rq);
        bit idle;
        idle = send_idle_pct > 0 && $urandom_range(99) < send_idle_pct;
        if (idle)
        begin
            req_ch.valid <= 1'b0;
            while (idle)
            begin
                @(posedge clk);
                idle = $urandom_range(99) < send_idle_pct;
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= rq.func;
        req_ch.word0 <= rq.w0;
        req_ch.word1 <= rq.w1;
        req_ch.word2 <= rq.w2;
        req_ch.word3 <= rq.w3;
        req_ch.tag <= rq.tag;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_drive(rq);
        if (rq.has_first)
        begin
            if (step_results.size() == 0)
                report_mismatch("typed first word missing", 0, rq.first_word);
            else if (step_results[0].fis_word !== rq.first_word
                     || step_results[0].outcome !== rq.first_outcome)
                report_mismatch("typed first word", step_results[0].fis_word,
                                rq.first_word);
        end
        foreach (step_results[i])
            pending_results.push_back(step_results[i]);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Requests that give no result still keep the block busy while they are decoded.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_signature_mode(input logic mode);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        atapi_mode = mode;
    endtask

    // Result side: random stall of ready and a check of every accepted result.
    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing expected", rsp_ch.fis_word, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.kind !== want.kind)
                        report_mismatch("kind", rsp_ch.kind, want.kind);
                    if (rsp_ch.fis_word !== want.fis_word)
                        report_mismatch("fis_word", rsp_ch.fis_word, want.fis_word);
                    if (rsp_ch.disk_sector !== want.sector)
                        report_mismatch("disk_sector", rsp_ch.disk_sector, want.sector);
                    if (rsp_ch.disk_sectors !== want.sectors)
                        report_mismatch("disk_sectors", rsp_ch.disk_sectors, want.sectors);
                    if (rsp_ch.disk_is_read !== want.is_read)
                        report_mismatch("disk_is_read", rsp_ch.disk_is_read, want.is_read);
                    if (rsp_ch.disk_slot !== want.slot)
                        report_mismatch("disk_slot", rsp_ch.disk_slot, want.slot);
                    if (rsp_ch.outcome !== want.outcome)
                        report_mismatch("outcome", rsp_ch.outcome, want.outcome);
                    if (rsp_ch.last !== want.last)
                        report_mismatch("last", rsp_ch.last, want.last);
                end
            end
            rsp_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: the run is stuck if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_sata_device_command_responder: done, errors");
            $finish;
        end
    end

    function automatic request_row_t reg_fis(input logic [7:0] opcode, input logic [31:0] w1,
                                            input logic [31:0] w2, input logic [31:0] w3);
        request_row_t rq;
        rq = '{func: FUNC_REG_FIS, w0: {8'($urandom_range(255)), opcode, 16'h8027},
               w1: w1, w2: w2, w3: w3, tag: '0, has_first: 1'b0, first_word: '0,
               first_outcome: '0};
        rq.w0[11:8] = 4'($urandom);
        return rq;
    endfunction

    function automatic request_row_t side_item(input logic [1:0] func, input logic [31:0] w3,
                                              input logic [5:0] tag);
        request_row_t rq;
        rq = '{func: func, w0: $urandom, w1: $urandom, w2: $urandom, w3: w3, tag: tag,
               has_first: 1'b0, first_word: '0, first_outcome: '0};
        return rq;
    endfunction

    // Random command: mostly a well-formed setup, command and completion chain.
    task automatic random_sequence();
        logic [7:0] cmds [22];
        logic [5:0] slot;
        request_row_t rq;
        cmds = '{CMD_READ_PIO, CMD_READ_PIO_EXT, CMD_READ_DMA_EXT, CMD_READ_MULT_EXT,
                 CMD_READ_MULT, CMD_READ_DMA, CMD_WRITE_PIO, CMD_WRITE_PIO_EXT,
                 CMD_WRITE_DMA_EXT, CMD_WRITE_MULT_EXT, CMD_WRITE_MULT, CMD_WRITE_DMA,
                 CMD_READ_FPDMA, CMD_WRITE_FPDMA, CMD_VERIFY, CMD_VERIFY_NR,
                 CMD_VERIFY_EXT, CMD_SET_FEATURES, CMD_FREEZE_LOCK, CMD_SET_MULTIPLE,
                 CMD_STANDBY, CMD_IDENTIFY};
        slot = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(NSLOT - 1));
        case ($urandom_range(9))
            0:
            begin
                rq = side_item(2'($urandom), $urandom, 6'($urandom));
                rq.w0 = $urandom;
                rq.w1 = $urandom;
                rq.w2 = $urandom;
                send_request(rq);
            end
            1:
            begin
                // Device control: sometimes raises soft reset, then a command.
                rq = side_item(FUNC_REG_FIS, {($urandom_range(2) == 0) ? 8'h04 : 8'($urandom),
                               24'($urandom)}, '0);
                rq.w0[15] = 1'b0;
                send_request(rq);
                send_request(reg_fis(cmds[$urandom_range(21)], $urandom, $urandom, $urandom));
            end
            default:
            begin
                send_request(side_item(FUNC_DMA_SETUP,
                                       ($urandom_range(7) == 0) ? 32'd0 : $urandom, slot));
                send_request(reg_fis(($urandom_range(15) == 0) ? 8'($urandom)
                                     : cmds[$urandom_range(21)], $urandom, $urandom,
                                     ($urandom_range(5) == 0) ? 32'd0 : $urandom));
                if ($urandom_range(3) != 0)
                    send_request(side_item(FUNC_DISK_DONE, $urandom, slot));
            end
        endcase
    endtask

    initial
    begin
        request_row_t directed [$];
        request_row_t rq;

        error_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        clear_drive_state();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_REG_FIS;
        req_ch.word0 = '0;
        req_ch.word1 = '0;
        req_ch.word2 = '0;
        req_ch.word3 = '0;
        req_ch.tag = '0;
        rsp_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed first words: the D2H header straight after reset,
        // unsupported opcodes and the DMA setup header.
        rq = side_item(FUNC_REG_FIS, 32'h0, '0);
        rq.w0 = 32'h0;
        rq.has_first = 1'b1;
        rq.first_word = 32'h0000_4034;
        directed.push_back(rq);
        rq = reg_fis(8'h00, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        rq.w0 = 32'hffff_ffff;
        rq.w0[23:16] = 8'h00;
        rq.has_first = 1'b1;
        rq.first_word = '0;
        rq.first_outcome = OUTCOME_UNSUP;
        directed.push_back(rq);
        rq = reg_fis(8'hff, '0, '0, '0);
        rq.has_first = 1'b1;
        rq.first_word = '0;
        rq.first_outcome = OUTCOME_UNSUP;
        directed.push_back(rq);
        // Transfer with no region count is refused; header still typed in.
        rq = reg_fis(CMD_READ_DMA, 32'h0, 32'h0, 32'h0);
        rq.has_first = 1'b1;
        rq.first_word = 32'h0000_0a41;
        rq.first_outcome = OUTCOME_REFUSED;
        directed.push_back(rq);
        directed.push_back(side_item(FUNC_DMA_SETUP, 32'hffff_ffff, 6'd32));
        directed.push_back(reg_fis(CMD_WRITE_DMA_EXT, 32'hffff_ffff, 32'hffff_ffff, 32'h0));
        directed.push_back(reg_fis(CMD_READ_FPDMA, 32'h1234_5678, 32'hff00_0000, 32'h0));
        directed.push_back(side_item(FUNC_DISK_DONE, '0, 6'd32));
        directed.push_back(side_item(FUNC_DISK_DONE, '0, 6'd63));
        directed.push_back(side_item(FUNC_DMA_SETUP, 32'd1, 6'd63));
        directed.push_back(reg_fis(CMD_WRITE_PIO, '0, '0, 32'hff));
        directed.push_back(reg_fis(CMD_IDENTIFY, 32'h1, '0, '0));
        directed.push_back(reg_fis(CMD_SET_MULTIPLE, '0, '0, 32'h10));
        directed.push_back(reg_fis(CMD_STANDBY, '0, '0, '0));
        directed.push_back(reg_fis(CMD_WRITE_FPDMA, '0, '0, 32'hffff));
        directed.push_back(side_item(2'd3, '0, '0));
        // Soft reset, then a command straight after it.
        rq = side_item(FUNC_REG_FIS, 32'h0400_0000, '0);
        rq.w0 = 32'h0;
        directed.push_back(rq);
        directed.push_back(reg_fis(CMD_VERIFY, '0, '0, '0));
        rq = side_item(FUNC_REG_FIS, 32'h0, '0);
        rq.w0 = 32'h0;
        directed.push_back(rq);

        foreach (directed[i])
            send_request(directed[i]);

        // ATAPI signature on the next soft reset.
        write_signature_mode(1'b1);
        rq = side_item(FUNC_REG_FIS, 32'h0400_0000, '0);
        rq.w0 = 32'h0;
        rq.has_first = 1'b1;
        rq.first_word = 32'h0140_4034;
        send_request(rq);
        send_request(side_item(FUNC_REG_FIS, 32'h0, '0));

        // Random part in three idling phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 31 : 0;
            write_signature_mode(phase == 1 ? 1'b1 : 1'b0);
            for (int k = 0; k < 35; k++)
            begin
                random_sequence();
                if (k == 20)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_sata_device_command_responder: done, clean");
        else
            $display("tb_sata_device_command_responder: done, errors");
        $finish;
    end
endmodule

/* filelist.f */
sv/sdcr_pkg.sv
sv/sdcr_req_if.sv
sv/sdcr_rsp_if.sv
sv/sdcr_slot_mem.sv
sv/sata_device_command_responder.sv
test/tb_sata_device_command_responder.sv
